[rtl/amrd_pkg.sv]
// Shared types, constants and helper functions for the motion/rotation detector.
package amrd_pkg;

  localparam int AXIS_W  = 16;
  localparam int LEVEL_W = 16;
  localparam int SUM_W   = 32;
  localparam int REM_W   = 18;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 24;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ONE_G      = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MOVE_THR   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_ROTATE_THR = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] ONE_G_RESET      = 16'd16384;
  localparam logic [CFG_W-1:0] MOVE_THR_RESET   = 16'd1638;
  localparam logic [CFG_W-1:0] ROTATE_THR_RESET = 16'd1638;

  // Multiplier operand select
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;       // capture input sample
    logic       mul_en;     // square one axis into product register
    logic [1:0] mul_sel;    // which axis to square
    logic       acc_first;  // accumulator <= product
    logic       acc_add;    // accumulator <= accumulator + product
    logic       root_clr;   // clear root and remainder
    logic       root_step;  // one root digit
    logic       lvl_en;     // register level and per-axis changes
    logic       commit;     // load output register, update history
  } cmd_t;

  // |a - b| for unsigned 16-bit values
  function automatic logic [LEVEL_W-1:0] absdiff_u(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
    logic [LEVEL_W:0] d;
    begin
      d = {1'b0, a} - {1'b0, b};
      absdiff_u = d[LEVEL_W] ? LEVEL_W'(-d) : d[LEVEL_W-1:0];
    end
  endfunction

  // |a - b| for signed 16-bit values, result fits 16 bits unsigned
  function automatic logic [LEVEL_W-1:0] absdiff_s(input logic [AXIS_W-1:0] a,
                                                   input logic [AXIS_W-1:0] b);
    logic [AXIS_W:0] d;
    begin
      d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
      absdiff_s = d[AXIS_W] ? LEVEL_W'(-d) : d[LEVEL_W-1:0];
    end
  endfunction

endpackage

[rtl/accel_motion_rotation_detector_core.sv]
// Top level of the accelerometer motion and rotation detector.
//
// Input stream s_*: one three-axis sample per transfer, 16-bit signed counts.
// Output stream m_*: one result per sample: moving and rotated flags and the
// motion level |floor(sqrt(x^2+y^2+z^2)) - one_g_counts|.
// Config channel cfg_*: index 0 one_g_counts, 1 move_threshold,
// 2 rotate_threshold; always ready, other indexes are ignored.
// From input transfer to m_tvalid a sample passes through the shared squarer,
// 16 square-root iterations at one bit per cycle, the level step and the
// commit. One sample is in flight at a time; the next sample is not taken
// until the last one has committed.
// s_tready is high only while no sample is in work; the result register
// holds a finished result while the next sample is taken and processed.
// If the receiver stalls, the finished sample waits at commit until the
// output register frees up.
// Reset (rst, synchronous) restores register defaults, clears the previous
// level and axis history; the first result after reset never flags rotated.
module accel_motion_rotation_detector_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [amrd_pkg::IN_W-1:0]    s_tdata,   // sample_x, sample_y, sample_z
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [amrd_pkg::OUT_W-1:0]   m_tdata,   // moving, rotated, motion_level, zero pad
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [amrd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [amrd_pkg::CFG_W-1:0]   cfg_data
);
  import amrd_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  amrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  amrd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata)
  );

endmodule

[rtl/amrd_ctrl.sv]
// Sequencer for the detector: squares, root iterations, level and commit steps.
module amrd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output amrd_pkg::cmd_t cmd
);
  import amrd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_LVL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQ;
          cnt_next   = '0;
        end
      end
      ST_SQ: begin
        cmd.mul_en    = (cnt[1:0] != 2'd3);
        cmd.mul_sel   = cnt[1:0];
        cmd.acc_first = (cnt[1:0] == 2'd1);
        cmd.acc_add   = (cnt[1:0] == 2'd2) || (cnt[1:0] == 2'd3);
        cmd.root_clr  = (cnt[1:0] == 2'd3);
        if (cnt[1:0] == 2'd3) begin
          state_next = ST_ROOT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 4'd1;
        if (cnt == 4'd15) begin
          state_next = ST_LVL;
        end
      end
      ST_LVL: begin
        cmd.lvl_en = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/amrd_dp.sv]
// Datapath: config registers, shared squarer, bit-serial square root, compares, history.
module amrd_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  amrd_pkg::cmd_t                cmd,
  input  logic                          cfg_valid,
  input  logic [amrd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [amrd_pkg::CFG_W-1:0]    cfg_data,
  input  logic [amrd_pkg::IN_W-1:0]     s_tdata,
  output logic [amrd_pkg::OUT_W-1:0]    m_tdata
);
  import amrd_pkg::*;

  logic [CFG_W-1:0]   one_g, move_thr, rotate_thr;
  logic [AXIS_W-1:0]  sx, sy, sz;
  logic [AXIS_W-1:0]  mul_op;
  logic [SUM_W-1:0]   prod, acc;
  logic [REM_W-1:0]   rem;
  logic [LEVEL_W-1:0] root;
  logic [REM_W+1:0]   rem_ext, trial, rem_sub;
  logic [LEVEL_W-1:0] level, dx, dy, dz;
  logic [LEVEL_W-1:0] last_level, last_x, last_y, last_z;
  logic               have_last;
  logic [LEVEL_W-1:0] delta, dmax_xy, dmax;
  logic               moving, rotated;
  logic               out_mov, out_rot;
  logic [LEVEL_W-1:0] out_level;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      one_g      <= ONE_G_RESET;
      move_thr   <= MOVE_THR_RESET;
      rotate_thr <= ROTATE_THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ONE_G:      one_g      <= cfg_data;
        CFG_MOVE_THR:   move_thr   <= cfg_data;
        CFG_ROTATE_THR: rotate_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= s_tdata[AXIS_W-1:0];
      sy <= s_tdata[2*AXIS_W-1:AXIS_W];
      sz <= s_tdata[3*AXIS_W-1:2*AXIS_W];
    end
  end

  // Shared squarer, one axis per cycle
  always_comb begin
    case (cmd.mul_sel)
      SEL_X:   mul_op = sx;
      SEL_Y:   mul_op = sy;
      default: mul_op = sz;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= SUM_W'($signed(mul_op) * $signed(mul_op));
    end
  end

  // Root digit: compare remainder with 4*root+1
  assign rem_ext = {rem, acc[SUM_W-1:SUM_W-2]};
  assign trial   = {2'b00, root, 2'b01};
  assign rem_sub = rem_ext - trial;

  // Sum of squares doubles as the radicand shift register
  always_ff @(posedge clk) begin
    if (cmd.acc_first) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc <= acc + prod;
    end else if (cmd.root_step) begin
      acc <= {acc[SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_clr) begin
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      if (rem_ext >= trial) begin
        rem  <= rem_sub[REM_W-1:0];
        root <= {root[LEVEL_W-2:0], 1'b1};
      end else begin
        rem  <= rem_ext[REM_W-1:0];
        root <= {root[LEVEL_W-2:0], 1'b0};
      end
    end
  end

  // Level and per-axis changes
  always_ff @(posedge clk) begin
    if (cmd.lvl_en) begin
      level <= absdiff_u(root, one_g);
      dx    <= absdiff_s(sx, last_x);
      dy    <= absdiff_s(sy, last_y);
      dz    <= absdiff_s(sz, last_z);
    end
  end

  // Threshold decisions
  assign delta   = absdiff_u(level, last_level);
  assign moving  = (delta > move_thr) || (level > move_thr);
  assign dmax_xy = (dy > dx) ? dy : dx;
  assign dmax    = (dz > dmax_xy) ? dz : dmax_xy;
  assign rotated = have_last && (dmax > rotate_thr);

  // History; rotation is suppressed until a first sample is seen
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
      last_x     <= '0;
      last_y     <= '0;
      last_z     <= '0;
      have_last  <= 1'b0;
    end else if (cmd.commit) begin
      last_level <= level;
      last_x     <= sx;
      last_y     <= sy;
      last_z     <= sz;
      have_last  <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_mov   <= moving;
      out_rot   <= rotated;
      out_level <= level;
    end
  end

  assign m_tdata = {(OUT_W - LEVEL_W - 2)'(0), out_level, out_rot, out_mov};

endmodule

[rtl/amrd_chk.sv]
// Port-level checker for the detector, bound to the top level.
module amrd_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [amrd_pkg::OUT_W-1:0]  m_tdata
);
  import amrd_pkg::*;

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> (s_tready && !m_tvalid))
    else $error("block not idle after reset");

  // A taken sample makes the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a transfer");

  // Pad bits above the level stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_W-1:LEVEL_W+2] == '0))
    else $error("output pad bits set");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind accel_motion_rotation_detector_core amrd_chk u_amrd_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
